### hw/rtl/dpsg_pkg.sv
// Shared types, constants and the attenuation ROM for the dual PSG sample generator.
`timescale 1ns / 1ps

package dpsg_pkg;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data;
    } t_in_item;

    typedef struct packed {
        logic [14:0] left_sample;
        logic [14:0] right_sample;
    } t_out_item;

    typedef enum logic [1:0] {
        MIX_L  = 2'd0,
        MIX_R  = 2'd1,
        MIX_LR = 2'd2
    } t_mix_sel;

    localparam logic [1:0]  CMD_TONE      = 2'd0;
    localparam logic [1:0]  CMD_NOISE     = 2'd1;
    localparam logic [1:0]  CMD_SAMPLE    = 2'd2;
    localparam logic [2:0]  REG_NOISE     = 3'd6;
    localparam logic [1:0]  NMODE_TONE2   = 2'd3;

    localparam logic [15:0] C_STEP_RST    = 16'd15052;
    localparam logic [16:0] C_FB_WHITE    = 17'h14002;
    localparam logic [16:0] C_FB_PERIODIC = 17'h08000;
    localparam logic [16:0] C_PRESET      = 17'h00f35;
    localparam logic [27:0] C_ONE         = 28'h0010000;
    localparam logic [16:0] C_ONE_17      = 17'h10000;
    localparam logic [31:0] C_SAT_SUM     = 32'h7fff0000;
    localparam logic [14:0] C_SAT         = 15'h7fff;

    function automatic logic [13:0] att_gain(input logic [3:0] a);
        logic [13:0] g;
        case (a)
            4'd0:    g = 14'd10922;
            4'd1:    g = 14'd8675;
            4'd2:    g = 14'd6891;
            4'd3:    g = 14'd5473;
            4'd4:    g = 14'd4348;
            4'd5:    g = 14'd3453;
            4'd6:    g = 14'd2743;
            4'd7:    g = 14'd2179;
            4'd8:    g = 14'd1731;
            4'd9:    g = 14'd1374;
            4'd10:   g = 14'd1092;
            4'd11:   g = 14'd867;
            4'd12:   g = 14'd689;
            4'd13:   g = 14'd547;
            4'd14:   g = 14'd434;
            default: g = 14'd0;
        endcase
        return g;
    endfunction

endpackage

### hw/rtl/dpsg_div.sv
// Iterative restoring divider, one quotient bit per cycle, remainder and quotient parity.
`timescale 1ns / 1ps

module dpsg_div
    import dpsg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_dividend,
    input  logic [26:0] i_divisor,
    output logic        o_done,
    output logic [15:0] o_rem,
    output logic        o_q_lsb
);

    logic        r_busy;
    logic        r_done;
    logic [3:0]  r_cnt;
    logic [15:0] r_rem;
    logic [15:0] r_dvd;
    logic        r_qlsb;

    logic [16:0] w_sh;
    logic        w_ge;
    logic [27:0] w_sub;

    always_comb begin
        w_sh  = {r_rem, r_dvd[15]};
        w_ge  = {11'd0, w_sh} >= {1'b0, i_divisor};
        w_sub = {11'd0, w_sh} - {1'b0, i_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 4'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= 16'd0;
            r_dvd <= i_dividend;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_sub[15:0] : w_sh[15:0];
            r_dvd  <= {r_dvd[14:0], 1'b0};
            r_qlsb <= w_ge;
        end
    end

    assign o_done  = r_done;
    assign o_rem   = r_rem;
    assign o_q_lsb = r_qlsb;

endmodule

### hw/rtl/dpsg_mix.sv
// Shared multiplier with left/right accumulators for the stereo mix.
`timescale 1ns / 1ps

module dpsg_mix
    import dpsg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_clear,
    input  logic        i_en,
    input  logic [16:0] i_a,
    input  logic [13:0] i_b,
    input  t_mix_sel    i_sel,
    output logic [31:0] o_left_sum,
    output logic [31:0] o_right_sum
);

    logic        r_pv;
    t_mix_sel    r_sel;
    logic [30:0] r_prod;
    logic [31:0] r_lsum;
    logic [31:0] r_rsum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_en && !i_clear;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        r_sel  <= i_sel;
        if (i_clear) begin
            r_lsum <= 32'd0;
            r_rsum <= 32'd0;
        end else if (r_pv) begin
            unique case (r_sel)
                MIX_L: begin
                    r_lsum <= r_lsum + {1'b0, r_prod};
                end
                MIX_R: begin
                    r_rsum <= r_rsum + {1'b0, r_prod};
                end
                default: begin
                    r_lsum <= r_lsum + {1'b0, r_prod};
                    r_rsum <= r_rsum + {1'b0, r_prod};
                end
            endcase
        end
    end

    assign o_left_sum  = r_lsum;
    assign o_right_sum = r_rsum;

endmodule

### hw/rtl/dual_psg_stereo_sample_generator.sv
// Top level: register writes, per-sample sequencer, tone/noise integration and output register.
//
//  channel  | signals                               | direction
//  ---------+---------------------------------------+----------
//  in item  | i_in_valid, o_in_stall, i_in_item     | in
//  out item | o_out_valid, i_out_stall, o_out_item  | out
//  config   | i_cfg_we, i_cfg_data (update_step)    | in
//
// A write item is taken directly from idle. A sample item steps each tone channel
// through ST_T_SET, and when its phase wraps also through the shared divider (ST_T_DIV)
// and ST_T_UPA/ST_T_UPB; then ST_N_RUN runs to each noise shifter event in turn and to
// the sample end, then the terms are mixed through the shared multiplier (ST_MIX, ST_DRAIN).
// Reset (synchronous, active low) loads power-on register values.
// The finished item waits in the output register; a new item is taken meanwhile.
`timescale 1ns / 1ps

module dual_psg_stereo_sample_generator
    import dpsg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_T_SET = 9'b000000010,
        ST_T_DIV = 9'b000000100,
        ST_T_UPA = 9'b000001000,
        ST_T_UPB = 9'b000010000,
        ST_N_RUN = 9'b000100000,
        ST_MIX   = 9'b001000000,
        ST_DRAIN = 9'b010000000,
        ST_DONE  = 9'b100000000
    } t_state;

    t_state      r_state;
    t_state      n_state;

    logic [15:0] r_step;
    logic [9:0]  r_freq  [2][3];
    logic [2:0]  r_last  [2];
    logic [26:0] r_thp   [2][3];
    logic [26:0] r_nhp;
    logic [2:0]  r_nmode;
    logic [16:0] r_shift;
    logic [13:0] r_gain  [2][4];
    logic [27:0] r_tpc   [3];
    logic        r_tlvl  [3];
    logic [27:0] r_npc;
    logic [16:0] r_hi    [4];
    logic [16:0] r_left;
    logic [1:0]  r_idx;
    logic [2:0]  r_k;
    logic [15:0] r_d;
    logic [27:0] r_pcn;
    logic [28:0] r_hsum;
    logic        r_oval;
    t_out_item   r_out;

    logic        w_acc;
    logic        w_sample;
    logic        w_wr;
    logic        w_ch;
    logic        w_latch;
    logic [7:0]  w_data;
    logic [2:0]  w_reg;
    logic        w_is_tone;
    logic [1:0]  w_tci;
    logic [15:0] w_step_e;
    logic [9:0]  w_fnew;
    logic [25:0] w_prod;
    logic [26:0] w_per;
    logic [26:0] w_nper;

    logic [27:0] w_pc;
    logic [26:0] w_p;
    logic        w_lvl;
    logic        w_fast;
    logic [16:0] w_d17;
    logic        w_div_done;
    logic [15:0] w_rem;
    logic        w_qlsb;
    logic        w_oddh;
    logic        w_newl;
    logic [28:0] w_p29;
    logic [28:0] w_half;
    logic [28:0] w_v;

    logic        w_nlt;
    logic [16:0] w_next;
    logic [27:0] w_npc_dec;
    logic [16:0] w_left_dec;
    logic [16:0] w_sh_x;

    logic        w_mix_en;
    logic [16:0] w_mix_a;
    logic [13:0] w_mix_b;
    t_mix_sel    w_mix_sel;
    logic [31:0] w_lsum;
    logic [31:0] w_rsum;
    logic        w_out_free;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_sample   = w_acc && (i_in_item.command == CMD_SAMPLE);
    assign w_wr       = w_acc && (i_in_item.command == CMD_TONE ||
                                  i_in_item.command == CMD_NOISE);
    assign w_out_free = !r_oval || !i_out_stall;

    // register write decode
    always_comb begin
        w_ch      = i_in_item.command[0];
        w_data    = i_in_item.data;
        w_latch   = w_data[7];
        w_reg     = w_latch ? w_data[6:4] : r_last[w_ch];
        w_is_tone = !w_reg[0] && (w_reg != REG_NOISE);
        w_tci     = (w_reg[2:1] == 2'd3) ? 2'd2 : w_reg[2:1];
        w_step_e  = (r_step == 16'd0) ? 16'd1 : r_step;
        w_fnew    = w_latch ? {r_freq[w_ch][w_tci][9:4], w_data[3:0]}
                            : {w_data[5:0], r_freq[w_ch][w_tci][3:0]};
        w_prod    = w_step_e * w_fnew;
        w_per     = (w_fnew == 10'd0) ? {11'd0, w_step_e} : {1'b0, w_prod};
        case (w_data[1:0])
            2'd0:    w_nper = {6'd0, w_step_e, 5'd0};
            2'd1:    w_nper = {5'd0, w_step_e, 6'd0};
            2'd2:    w_nper = {4'd0, w_step_e, 7'd0};
            default: w_nper = {r_thp[1][2][25:0], 1'b0};
        endcase
    end

    // tone integration
    always_comb begin
        w_pc   = r_tpc[r_idx];
        w_p    = r_thp[0][r_idx];
        w_lvl  = r_tlvl[r_idx];
        w_fast = w_pc > C_ONE;
        w_d17  = C_ONE_17 - w_pc[16:0];
        w_p29  = {2'd0, w_p};
        w_oddh = !w_qlsb;
        w_newl = w_oddh ? !w_lvl : w_lvl;
        w_half = (r_hsum - (w_oddh ? w_p29 : 29'd0)) >> 1;
        w_v    = (w_lvl ? {1'b0, w_pc} : 29'd0) + w_half
               + ((w_oddh && w_newl) ? w_p29 : 29'd0)
               - (w_newl ? {1'b0, r_pcn} : 29'd0);
    end

    // noise integration
    always_comb begin
        w_nlt      = r_npc < {11'd0, r_left};
        w_next     = w_nlt ? r_npc[16:0] : r_left;
        w_npc_dec  = r_npc - {11'd0, w_next};
        w_left_dec = r_left - w_next;
        w_sh_x     = r_shift[0] ? (r_shift ^ (r_nmode[2] ? C_FB_WHITE : C_FB_PERIODIC))
                                : r_shift;
    end

    // mix term selection
    always_comb begin
        w_mix_en = (r_state == ST_MIX);
        case (r_k)
            3'd0:    begin w_mix_a = r_hi[0]; w_mix_b = r_gain[0][0]; w_mix_sel = MIX_L;  end
            3'd1:    begin w_mix_a = r_hi[0]; w_mix_b = r_gain[1][0]; w_mix_sel = MIX_R;  end
            3'd2:    begin w_mix_a = r_hi[1]; w_mix_b = r_gain[0][1]; w_mix_sel = MIX_L;  end
            3'd3:    begin w_mix_a = r_hi[1]; w_mix_b = r_gain[1][1]; w_mix_sel = MIX_R;  end
            3'd4:    begin w_mix_a = r_hi[2]; w_mix_b = r_gain[0][2]; w_mix_sel = MIX_L;  end
            3'd5:    begin w_mix_a = r_hi[2]; w_mix_b = r_gain[1][2]; w_mix_sel = MIX_R;  end
            default: begin w_mix_a = r_hi[3]; w_mix_b = r_gain[1][3]; w_mix_sel = MIX_LR; end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_sample) n_state = ST_T_SET;
            ST_T_SET: begin
                if (!w_fast) begin
                    n_state = ST_T_DIV;
                end else if (r_idx == 2'd2) begin
                    n_state = ST_N_RUN;
                end
            end
            ST_T_DIV: if (w_div_done) n_state = ST_T_UPA;
            ST_T_UPA: n_state = ST_T_UPB;
            ST_T_UPB: n_state = (r_idx == 2'd2) ? ST_N_RUN : ST_T_SET;
            ST_N_RUN: if (w_left_dec == 17'd0) n_state = ST_MIX;
            ST_MIX:   if (r_k == 3'd6) n_state = ST_DRAIN;
            ST_DRAIN: n_state = ST_DONE;
            ST_DONE:  if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DONE && w_out_free) begin
                r_oval <= 1'b1;
            end else if (!i_out_stall) begin
                r_oval <= 1'b0;
            end
        end
    end

    // chip registers and sample state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= C_STEP_RST;
            r_nhp   <= {11'd0, C_STEP_RST};
            r_nmode <= 3'd0;
            r_shift <= 17'd0;
            r_npc   <= {12'd0, C_STEP_RST};
            for (int c = 0; c < 2; c++) begin
                r_last[c] <= 3'd0;
                for (int t = 0; t < 3; t++) begin
                    r_freq[c][t] <= 10'd0;
                    r_thp[c][t]  <= {11'd0, C_STEP_RST};
                end
                for (int g = 0; g < 4; g++) begin
                    r_gain[c][g] <= 14'd0;
                end
            end
            for (int t = 0; t < 3; t++) begin
                r_tpc[t]  <= {12'd0, C_STEP_RST};
                r_tlvl[t] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                r_step <= i_cfg_data;
            end
            if (w_wr) begin
                if (w_latch) begin
                    r_last[w_ch] <= w_reg;
                end
                if (w_is_tone) begin
                    r_freq[w_ch][w_tci] <= w_fnew;
                    r_thp[w_ch][w_tci]  <= w_per;
                    if (w_ch && w_tci == 2'd2 && r_nmode[1:0] == NMODE_TONE2) begin
                        r_nhp <= {w_per[25:0], 1'b0};
                    end
                end else if (w_latch && w_reg == REG_NOISE) begin
                    if (w_ch) begin
                        r_nmode <= w_data[2:0];
                        r_nhp   <= w_nper;
                        r_shift <= C_PRESET;
                    end
                end else if (w_latch) begin
                    r_gain[w_ch][w_reg[2:1]] <= att_gain(w_data[3:0]);
                end
            end
            if (r_state == ST_T_SET && w_fast) begin
                r_tpc[r_idx] <= w_pc - C_ONE;
            end
            if (r_state == ST_T_UPB) begin
                r_tpc[r_idx]  <= r_pcn;
                r_tlvl[r_idx] <= w_newl;
            end
            if (r_state == ST_N_RUN && w_npc_dec == 28'd0) begin
                r_shift <= {1'b0, w_sh_x[16:1]};
                r_npc   <= {1'b0, r_nhp};
            end else if (r_state == ST_N_RUN) begin
                r_npc <= w_npc_dec;
            end
        end
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= 2'd0;
            r_k    <= 3'd0;
            r_left <= C_ONE_17;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    r_idx   <= 2'd0;
                    r_k     <= 3'd0;
                    r_left  <= C_ONE_17;
                    r_hi[3] <= 17'd0;
                end
                ST_T_SET: begin
                    r_d <= w_d17[15:0];
                    if (w_fast) begin
                        r_hi[r_idx] <= w_lvl ? C_ONE_17 : 17'd0;
                        r_idx       <= r_idx + 2'd1;
                    end
                end
                ST_T_UPA: begin
                    r_pcn  <= {1'b0, w_p} - {12'd0, w_rem};
                    r_hsum <= {13'd0, r_d} + w_p29 - {13'd0, w_rem};
                end
                ST_T_UPB: begin
                    r_hi[r_idx] <= w_v[16:0];
                    r_idx       <= r_idx + 2'd1;
                end
                ST_N_RUN: begin
                    r_left <= w_left_dec;
                    if (r_shift[0]) begin
                        r_hi[3] <= r_hi[3] + w_next;
                    end
                end
                ST_MIX: begin
                    r_k <= r_k + 3'd1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && w_out_free) begin
            r_out.left_sample  <= (w_lsum > C_SAT_SUM) ? C_SAT : w_lsum[30:16];
            r_out.right_sample <= (w_rsum > C_SAT_SUM) ? C_SAT : w_rsum[30:16];
        end
    end

    assign o_out_valid = r_oval;
    assign o_out_item  = r_out;

    dpsg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == ST_T_SET && !w_fast),
        .i_dividend (w_d17[15:0]),
        .i_divisor  (w_p),
        .o_done     (w_div_done),
        .o_rem      (w_rem),
        .o_q_lsb    (w_qlsb)
    );

    dpsg_mix u_mix (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (w_sample),
        .i_en        (w_mix_en),
        .i_a         (w_mix_a),
        .i_b         (w_mix_b),
        .i_sel       (w_mix_sel),
        .o_left_sum  (w_lsum),
        .o_right_sum (w_rsum)
    );

    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sample |=> o_in_stall) else $error("sample item did not start the sequencer");

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= C_ONE_17) else $error("noise time left out of range");

    a_npc_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_npc != 28'd0) else $error("noise phase reached zero");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == ST_T_DIV) else $error("divider done outside wait state");

endmodule

### test/testbench.sv
// Self-checking testbench for the dual PSG stereo sample generator.
`timescale 1ns / 1ps

class psg_scoreboard;
    localparam longint FIX = 64'h10000;

    int unsigned atten[16] = '{10922, 8675, 6891, 5473, 4348, 3453, 2743, 2179,
                               1731, 1374, 1092, 867, 689, 547, 434, 0};
    bit [15:0]   step;
    bit [9:0]    regs[2][8];
    bit [2:0]    last_reg[2];
    longint      half_per[2][4];
    longint      phase[2][4];
    bit          level[2][4];
    bit [16:0]   shifter[2];
    bit [16:0]   feedback[2];
    longint      gain[2][4];
    dpsg_pkg::t_out_item samples_due[$];
    int          errors;

    function new();
        step = dpsg_pkg::C_STEP_RST;
        for (int ch = 0; ch < 2; ch++) begin
            for (int i = 0; i < 8; i++) regs[ch][i] = (i % 2) ? 10'h00f : 10'h000;
            last_reg[ch] = 0;
            shifter[ch] = 0;
            feedback[ch] = 0;
            for (int i = 0; i < 4; i++) begin
                half_per[ch][i] = step;
                phase[ch][i] = step;
                level[ch][i] = 0;
                gain[ch][i] = 0;
            end
        end
        errors = 0;
    endfunction

    function void set_step(bit [15:0] v);
        step = v;
    endfunction

    function longint eff_step();
        return (step == 0) ? 1 : longint'(step);
    endfunction

    function void set_period(int ch, int r);
        longint p;
        p = eff_step() * longint'(regs[ch][r]);
        if (p == 0) p = eff_step();
        half_per[ch][r >> 1] = p;
        if (r == 4 && regs[ch][dpsg_pkg::REG_NOISE][1:0] == dpsg_pkg::NMODE_TONE2)
            half_per[ch][3] = 2 * half_per[ch][2];
    endfunction

    function void write_reg(int ch, bit [7:0] d);
        int r;
        bit [1:0] n;
        if (d[7]) begin
            r = d[6:4];
            last_reg[ch] = r;
            regs[ch][r] = {regs[ch][r][9:4], d[3:0]};
            if (r == 0 || r == 2 || r == 4) begin
                set_period(ch, r);
            end else if (r == dpsg_pkg::REG_NOISE) begin
                feedback[ch] = regs[ch][r][2] ? dpsg_pkg::C_FB_WHITE : dpsg_pkg::C_FB_PERIODIC;
                n = regs[ch][r][1:0];
                half_per[ch][3] = (n == dpsg_pkg::NMODE_TONE2) ? 2 * half_per[ch][2]
                                                               : eff_step() << (5 + n);
                shifter[ch] = dpsg_pkg::C_PRESET;
                level[ch][3] = shifter[ch][0];
            end else begin
                gain[ch][r >> 1] = atten[d[3:0]];
            end
        end else begin
            r = last_reg[ch];
            if (r == 0 || r == 2 || r == 4) begin
                regs[ch][r] = {d[5:0], regs[ch][r][3:0]};
                set_period(ch, r);
            end
        end
    endfunction

    function void advance(int ch, output longint hi[4]);
        longint p, v, h, rest, nxt;
        for (int i = 0; i < 3; i++) begin
            p = half_per[ch][i];
            v = 0;
            if (p < 1) p = 1;
            if (level[ch][i]) v += phase[ch][i];
            phase[ch][i] -= FIX;
            if (phase[ch][i] <= 0) begin
                h = (-phase[ch][i]) / p + 1;
                phase[ch][i] += h * p;
                if (h % 2) begin
                    v += ((h - 1) / 2) * p;
                    level[ch][i] = ~level[ch][i];
                    if (level[ch][i]) v += p;
                end else begin
                    v += (h / 2) * p;
                end
            end
            if (level[ch][i]) v -= phase[ch][i];
            hi[i] = v;
        end
        hi[3] = 0;
        rest = FIX;
        do begin
            p = half_per[ch][3];
            nxt = (phase[ch][3] < rest) ? phase[ch][3] : rest;
            if (p < 1) p = 1;
            if (level[ch][3]) hi[3] += phase[ch][3];
            phase[ch][3] -= nxt;
            if (phase[ch][3] <= 0) begin
                if (shifter[ch][0]) shifter[ch] ^= feedback[ch];
                shifter[ch] = shifter[ch] >> 1;
                level[ch][3] = shifter[ch][0];
                phase[ch][3] += p;
                if (level[ch][3]) hi[3] += p;
            end
            if (level[ch][3]) hi[3] -= phase[ch][3];
            rest -= nxt;
        end while (rest > 0);
    endfunction

    function bit [14:0] saturate(longint unsigned s);
        longint unsigned lim;
        lim = 64'h7fff * FIX;
        if (s > lim) s = lim;
        return 15'(s / FIX);
    endfunction

    function void note(dpsg_pkg::t_in_item it);
        longint tv[4], nv[4];
        longint unsigned l, r;
        dpsg_pkg::t_out_item o;
        if (it.command == dpsg_pkg::CMD_TONE || it.command == dpsg_pkg::CMD_NOISE) begin
            write_reg(int'(it.command), it.data);
        end else if (it.command == dpsg_pkg::CMD_SAMPLE) begin
            advance(0, tv);
            advance(1, nv);
            l = 0;
            r = 0;
            for (int i = 0; i < 3; i++) begin
                l += longint'(tv[i]) * gain[0][i];
                r += longint'(tv[i]) * gain[1][i];
            end
            l += nv[3] * gain[1][3];
            r += nv[3] * gain[1][3];
            o.left_sample = saturate(l);
            o.right_sample = saturate(r);
            samples_due.push_back(o);
        end
    endfunction

    function void check(dpsg_pkg::t_out_item got);
        dpsg_pkg::t_out_item exp_item;
        if (samples_due.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected sample L=%0d R=%0d",
                                       got.left_sample, got.right_sample);
            return;
        end
        exp_item = samples_due.pop_front();
        if (got.left_sample !== exp_item.left_sample
            || got.right_sample !== exp_item.right_sample) begin
            errors++;
            if (errors <= 10) $display("sample mismatch: exp L=%0d R=%0d got L=%0d R=%0d",
                                       exp_item.left_sample, exp_item.right_sample,
                                       got.left_sample, got.right_sample);
        end
    endfunction
endclass

module testbench;
    import dpsg_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_item;

    psg_scoreboard sb = new();
    int in_idle_pct = 0;
    int out_idle_pct = 0;
    int hold_left = 0;

    dual_psg_stereo_sample_generator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) sb.note(i_in_item);
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check(o_out_item);
    end

    task automatic send_item(input logic [1:0] cmd, input logic [7:0] d);
        t_in_item it;
        it.command = cmd;
        it.data = d;
        if ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < in_idle_pct) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_random();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40) begin
            send_item(CMD_SAMPLE, 8'($urandom));
        end else if (pick < 43) begin
            send_item(2'd3, 8'($urandom));
        end else if ($urandom_range(99) < 70) begin
            send_item(2'($urandom_range(1)), {1'b1, 7'($urandom)});
        end else begin
            send_item(2'($urandom_range(1)), {1'b0, 7'($urandom)});
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.samples_due.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_step(input logic [15:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_step(v);
    endtask

    task automatic slow_step_items();
        send_item(CMD_TONE, 8'h80);
        send_item(CMD_TONE, 8'h3f);
        send_item(CMD_TONE, 8'h90);
        send_item(CMD_NOISE, 8'he4);
        send_item(CMD_NOISE, 8'hf0);
        send_item(CMD_SAMPLE, 8'h00);
        send_item(CMD_TONE, 8'hc5);
        send_item(CMD_SAMPLE, 8'h00);
        send_item(CMD_SAMPLE, 8'h00);
    endtask

    initial begin
        #100_000_000;
        $display("[dual_psg_stereo_sample_generator] ERROR");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset state, extremes, tone, noise and attenuation writes, ignored bytes
        send_item(CMD_SAMPLE, 8'h00);
        send_item(CMD_NOISE, 8'hff);
        send_item(CMD_SAMPLE, 8'h00);
        send_item(CMD_TONE, 8'h80);
        send_item(CMD_TONE, 8'h3f);
        send_item(CMD_TONE, 8'h90);
        send_item(CMD_TONE, 8'h2a);
        send_item(CMD_TONE, 8'hbf);
        send_item(CMD_TONE, 8'h00);
        send_item(CMD_TONE, 8'hd8);
        send_item(CMD_NOISE, 8'hb3);
        send_item(CMD_NOISE, 8'he7);
        send_item(CMD_NOISE, 8'h55);
        send_item(CMD_NOISE, 8'hf0);
        send_item(CMD_SAMPLE, 8'hff);
        send_item(CMD_TONE, 8'hc1);
        send_item(CMD_TONE, 8'h7f);
        send_item(CMD_NOISE, 8'he3);
        send_item(CMD_NOISE, 8'hd2);
        send_item(2'd3, 8'hff);
        send_item(CMD_SAMPLE, 8'h00);
        send_item(CMD_SAMPLE, 8'h00);

        in_idle_pct = 25;
        out_idle_pct = 56;
        repeat (150) send_random();
        drain();

        write_step(16'hffff);
        in_idle_pct = 56;
        out_idle_pct = 25;
        repeat (40) send_random();
        hold_left = 3000;
        repeat (80) send_random();
        drain();

        in_idle_pct = 0;
        out_idle_pct = 0;
        write_step(16'd1);
        slow_step_items();
        drain();
        write_step(16'd0);
        slow_step_items();
        drain();

        write_step(16'($urandom_range(65535, 2000)));
        repeat (120) send_random();
        drain();

        if (sb.errors == 0) begin
            $display("[dual_psg_stereo_sample_generator] OK");
        end else begin
            $display("[dual_psg_stereo_sample_generator] ERROR");
        end
        $finish;
    end
endmodule
